/* design/time_range_index_table_assert.svh */
// ---------------------------------------------------------------------------
// time_range_index_table_assert.svh
// assertion macros shared by the time range index table rtl
// ---------------------------------------------------------------------------
`ifndef TIME_RANGE_INDEX_TABLE_ASSERT_SVH
`define TIME_RANGE_INDEX_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TRI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/tri_pkg.sv */
// ---------------------------------------------------------------------------
// tri_pkg
// types, codes and constants of the time range index table
// ---------------------------------------------------------------------------
package tri_pkg;

    // field widths
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int TIME_W = 64;
    localparam int WORD_W = 32;

    // stream word widths
    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = 72;

    // default table depth
    localparam int DEF_MAX_ENTRIES = 64;

    // input kinds
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_LIST   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_BAD_POS  = 2'd3
    } t_status;

    // series value types
    typedef enum logic [1:0] {
        VT_BOOL   = 2'd0,
        VT_INT    = 2'd1,
        VT_DOUBLE = 2'd2,
        VT_OTHER  = 2'd3
    } t_vtype;

    // block sizes by value type
    localparam logic [WORD_W-1:0] APP_BOOL_BYTES   = 32'd28;
    localparam logic [WORD_W-1:0] APP_INT_BYTES    = 32'd39;
    localparam logic [WORD_W-1:0] APP_DOUBLE_BYTES = 32'd43;
    localparam logic [WORD_W-1:0] UPD_BOOL_ADD     = 32'd17;
    localparam logic [WORD_W-1:0] UPD_INT_BYTES    = 32'd28;
    localparam logic [WORD_W-1:0] UPD_DOUBLE_BYTES = 32'd32;

    // one stored table entry
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [WORD_W-1:0] offset;
        logic [TIME_W-1:0] w_end;
        logic [TIME_W-1:0] w_start;
    } t_entry;

    // shared unit results
    typedef struct packed {
        logic              in_window;
        logic [WORD_W-1:0] sum;
    } t_alu_res;

endpackage

/* design/tri_alu.sv */
// ---------------------------------------------------------------------------
// tri_alu
// shared window compare and saturating size adder
// ---------------------------------------------------------------------------
module tri_alu (
    input  logic [tri_pkg::TIME_W-1:0] i_query,
    input  logic [tri_pkg::TIME_W-1:0] i_lo,
    input  logic [tri_pkg::TIME_W-1:0] i_hi,
    input  logic [tri_pkg::WORD_W-1:0] i_base,
    input  logic [tri_pkg::WORD_W-1:0] i_addend,
    output tri_pkg::t_alu_res          o_res
);

    logic [tri_pkg::WORD_W:0] wide_sum;

    // inclusive window test, unsigned
    assign o_res.in_window = (i_query >= i_lo) && (i_query <= i_hi);

    // add with saturation at all ones
    assign wide_sum  = {1'b0, i_base} + {1'b0, i_addend};
    assign o_res.sum = wide_sum[tri_pkg::WORD_W] ? '1 : wide_sum[tri_pkg::WORD_W-1:0];

endmodule

/* design/time_range_index_table.sv */
// ---------------------------------------------------------------------------
// time_range_index_table
// table of data-block index entries with append, update, time search, list
// ---------------------------------------------------------------------------
// channel   dir  signals                        content
// s_axis    in   tvalid tready tdata tuser      command word, kind in tuser
// m_axis    out  tvalid tready tdata tuser tlast result word, status in tuser
// cfg       in   i_cfg_wr_en i_cfg_wr_data      value type register
//
// append writes and answers in one state after the accept; update reads, then
// writes (a bad position answers at the read). search and list make one table
// read per cycle while not stalled, through the single read port, compared in the shared unit.
// a result word not yet taken stalls the walk when a further hit or the final
// word must go out, and holds append and update results the same way.
// reset clears count and handshake state and sets the value type to other, not the table.
// ---------------------------------------------------------------------------
module time_range_index_table #(
    parameter int MAX_ENTRIES = tri_pkg::DEF_MAX_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [1:0]                       i_cfg_wr_data,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_time, end_time, entry_bytes, entry_offset, position, query_time
    input  logic [tri_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic [1:0]                       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // match_offset, match_bytes, entry_index
    output logic [tri_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

`include "time_range_index_table_assert.svh"

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [tri_pkg::CNT_W-1:0] LIMIT = tri_pkg::CNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state                        r_state;
    logic [tri_pkg::CNT_W-1:0]     r_count;
    tri_pkg::t_vtype               r_value_type;
    logic [tri_pkg::IDX_W-1:0]     r_idx;

    // latched command
    tri_pkg::t_kind                r_kind;
    logic [tri_pkg::TIME_W-1:0]    r_start;
    logic [tri_pkg::TIME_W-1:0]    r_end;
    logic [tri_pkg::WORD_W-1:0]    r_bytes;
    logic [tri_pkg::WORD_W-1:0]    r_offset;
    logic [tri_pkg::IDX_W-1:0]     r_pos;
    logic [tri_pkg::TIME_W-1:0]    r_query;

    // held hit, emitted once the next hit or the end is known
    logic                          r_pend_valid;
    logic [tri_pkg::WORD_W-1:0]    r_pend_offset;
    logic [tri_pkg::WORD_W-1:0]    r_pend_bytes;
    logic [tri_pkg::IDX_W-1:0]     r_pend_index;

    // output register
    logic                          r_out_valid;
    tri_pkg::t_status              r_out_status;
    logic [tri_pkg::WORD_W-1:0]    r_out_offset;
    logic [tri_pkg::WORD_W-1:0]    r_out_bytes;
    logic [tri_pkg::IDX_W-1:0]     r_out_index;
    logic                          r_out_last;

    // table memory
    tri_pkg::t_entry               r_mem [MAX_ENTRIES];
    tri_pkg::t_entry               r_rd_data;

    logic                          mem_rd_en;
    logic [AW-1:0]                 mem_rd_addr;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    tri_pkg::t_entry               mem_wr_data;

    tri_pkg::t_alu_res             alu_res;
    logic [tri_pkg::WORD_W-1:0]    alu_addend;
    logic [tri_pkg::WORD_W-1:0]    app_size;
    logic [tri_pkg::WORD_W-1:0]    upd_size;
    logic                          in_accept;
    logic                          out_free;
    logic                          out_load;
    logic                          table_full;
    logic                          pos_bad;
    logic                          scan_hit;
    logic                          scan_adv;
    logic                          scan_last;
    tri_pkg::t_kind                in_kind;

    assign in_kind       = tri_pkg::t_kind'(s_axis_tuser);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign table_full    = (r_count >= LIMIT);
    assign pos_bad       = ({1'b0, r_pos} >= r_count);
    assign scan_hit      = (r_kind == tri_pkg::KIND_LIST) || alu_res.in_window;
    assign scan_adv      = !scan_hit || !r_pend_valid || out_free;
    assign scan_last     = (({1'b0, r_idx} + tri_pkg::CNT_W'(1)) == r_count);

    // shared compare and add unit
    assign alu_addend = (r_value_type == tri_pkg::VT_BOOL) ? tri_pkg::UPD_BOOL_ADD : r_bytes;

    tri_alu u_alu (
        .i_query  (r_query),
        .i_lo     (r_rd_data.w_start),
        .i_hi     (r_rd_data.w_end),
        .i_base   (r_rd_data.bytes),
        .i_addend (alu_addend),
        .o_res    (alu_res)
    );

    // size of an appended entry
    always_comb begin
        unique case (r_value_type)
            tri_pkg::VT_BOOL:   app_size = tri_pkg::APP_BOOL_BYTES;
            tri_pkg::VT_INT:    app_size = tri_pkg::APP_INT_BYTES;
            tri_pkg::VT_DOUBLE: app_size = tri_pkg::APP_DOUBLE_BYTES;
            default:            app_size = r_bytes;
        endcase
    end

    // size of an updated entry
    always_comb begin
        unique case (r_value_type)
            tri_pkg::VT_INT:    upd_size = tri_pkg::UPD_INT_BYTES;
            tri_pkg::VT_DOUBLE: upd_size = tri_pkg::UPD_DOUBLE_BYTES;
            default:            upd_size = alu_res.sum;
        endcase
    end

    // result register load
    always_comb begin
        unique case (r_state)
            ST_APP:    out_load = out_free;
            ST_UPD_RD: out_load = pos_bad && out_free;
            ST_UPD_WR: out_load = out_free;
            ST_SCAN:   out_load = scan_adv && scan_hit && r_pend_valid;
            ST_FIN:    out_load = out_free;
            default:   out_load = 1'b0;
        endcase
    end

    // memory port control
    always_comb begin
        mem_rd_en           = 1'b0;
        mem_rd_addr         = '0;
        mem_wr_en           = 1'b0;
        mem_wr_addr         = r_count[AW-1:0];
        mem_wr_data.w_start = r_start;
        mem_wr_data.w_end   = r_end;
        mem_wr_data.offset  = r_offset;
        mem_wr_data.bytes   = app_size;
        unique case (r_state)
            ST_IDLE: begin
                mem_rd_en = in_accept && (in_kind == tri_pkg::KIND_SEARCH ||
                                          in_kind == tri_pkg::KIND_LIST) &&
                            (r_count != '0);
            end
            ST_APP: begin
                mem_wr_en = out_free && !table_full;
            end
            ST_UPD_RD: begin
                mem_rd_en   = !pos_bad;
                mem_rd_addr = r_pos[AW-1:0];
            end
            ST_UPD_WR: begin
                mem_wr_en          = out_free;
                mem_wr_addr        = r_pos[AW-1:0];
                mem_wr_data.offset = r_rd_data.offset;
                mem_wr_data.bytes  = upd_size;
            end
            ST_SCAN: begin
                mem_rd_en   = scan_adv && !scan_last;
                mem_rd_addr = AW'(r_idx + tri_pkg::IDX_W'(1));
            end
            default: begin
            end
        endcase
    end

    // table storage with registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    // value type register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_type <= tri_pkg::VT_OTHER;
        end else if (i_cfg_wr_en) begin
            r_value_type <= tri_pkg::t_vtype'(i_cfg_wr_data);
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_kind   <= in_kind;
                        r_start  <= s_axis_tdata[63:0];
                        r_end    <= s_axis_tdata[127:64];
                        r_bytes  <= s_axis_tdata[159:128];
                        r_offset <= s_axis_tdata[191:160];
                        r_pos    <= s_axis_tdata[197:192];
                        r_query  <= s_axis_tdata[261:198];
                        r_idx    <= '0;
                        r_pend_valid <= 1'b0;
                        unique case (in_kind)
                            tri_pkg::KIND_APPEND: r_state <= ST_APP;
                            tri_pkg::KIND_UPDATE: r_state <= ST_UPD_RD;
                            default: r_state <= (r_count != '0) ? ST_SCAN : ST_FIN;
                        endcase
                    end
                end
                ST_APP: begin
                    if (out_free) begin
                        r_out_last  <= 1'b1;
                        if (table_full) begin
                            r_out_status <= tri_pkg::STAT_FULL;
                            r_out_offset <= '0;
                            r_out_bytes  <= '0;
                            r_out_index  <= '0;
                        end else begin
                            r_out_status <= tri_pkg::STAT_OK;
                            r_out_offset <= r_offset;
                            r_out_bytes  <= app_size;
                            r_out_index  <= r_count[tri_pkg::IDX_W-1:0];
                            r_count      <= r_count + tri_pkg::CNT_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_UPD_RD: begin
                    if (!pos_bad) begin
                        r_state <= ST_UPD_WR;
                    end else if (out_free) begin
                        r_out_last   <= 1'b1;
                        r_out_status <= tri_pkg::STAT_BAD_POS;
                        r_out_offset <= '0;
                        r_out_bytes  <= '0;
                        r_out_index  <= '0;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_UPD_WR: begin
                    if (out_free) begin
                        r_out_last   <= 1'b1;
                        r_out_status <= tri_pkg::STAT_OK;
                        r_out_offset <= r_rd_data.offset;
                        r_out_bytes  <= upd_size;
                        r_out_index  <= r_pos;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (scan_adv) begin
                        // a new hit pushes the held one out, not last
                        if (scan_hit) begin
                            if (r_pend_valid) begin
                                r_out_last   <= 1'b0;
                                r_out_status <= tri_pkg::STAT_OK;
                                r_out_offset <= r_pend_offset;
                                r_out_bytes  <= r_pend_bytes;
                                r_out_index  <= r_pend_index;
                            end
                            r_pend_valid  <= 1'b1;
                            r_pend_offset <= r_rd_data.offset;
                            r_pend_bytes  <= r_rd_data.bytes;
                            r_pend_index  <= r_idx;
                        end
                        if (scan_last) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_idx <= r_idx + tri_pkg::IDX_W'(1);
                        end
                    end
                end
                ST_FIN: begin
                    // final hit with last set, or one no-match word
                    if (out_free) begin
                        r_out_last  <= 1'b1;
                        if (r_pend_valid) begin
                            r_out_status <= tri_pkg::STAT_OK;
                            r_out_offset <= r_pend_offset;
                            r_out_bytes  <= r_pend_bytes;
                            r_out_index  <= r_pend_index;
                        end else begin
                            r_out_status <= tri_pkg::STAT_NO_MATCH;
                            r_out_offset <= '0;
                            r_out_bytes  <= '0;
                            r_out_index  <= '0;
                        end
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_index, r_out_bytes, r_out_offset};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    // checks
    `TRI_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= LIMIT,
        "entry count beyond table depth")
    `TRI_ASSERT_NOW(a_pend_only_in_walk, r_pend_valid,
        r_state == ST_SCAN || r_state == ST_FIN,
        "held hit outside a search or list")
    `TRI_ASSERT_NOW(a_write_in_table, mem_wr_en,
        ({1'b0, r_pos} < r_count && r_state == ST_UPD_WR) ||
        (r_count < LIMIT && r_state == ST_APP),
        "table write outside stored or next entry")
    `TRI_ASSERT_NOW(a_count_step,
        $past(i_rst_n) && (r_count != $past(r_count)),
        r_count == $past(r_count) + tri_pkg::CNT_W'(1),
        "entry count changed by other than one append")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stream-level test of the time range index table. commands go in on the
// slave side. a predictor keeps its own copy of the table and the value type
// and queues the words each command should produce. a checker compares every
// result word with the oldest queued one. directed tests cover the empty
// table, sizes by value type, saturation, bad positions, a full table and
// inclusive window bounds. random phases follow, at least one per value type.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH = tri_pkg::DEF_MAX_ENTRIES;
    localparam int IDLE_LIMIT  = 3000;
    localparam int MAX_PRINTS  = 30;

    // one command word, as the block sees it
    typedef struct packed {
        tri_pkg::t_kind    kind;
        logic [63:0]       start_time;
        logic [63:0]       end_time;
        logic [31:0]       entry_bytes;
        logic [31:0]       entry_offset;
        logic [5:0]        position;
        logic [63:0]       query_time;
    } t_index_cmd;

    // one result word
    typedef struct packed {
        tri_pkg::t_status  status;
        logic [31:0]       offset;
        logic [31:0]       bytes;
        logic [5:0]        index;
        logic              last;
    } t_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [1:0]                     i_cfg_wr_data = 2'd0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // start_time, end_time, entry_bytes, entry_offset, position, query_time
    logic [tri_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // kind
    logic [1:0]                     s_axis_tuser = 2'd0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // match_offset, match_bytes, entry_index
    logic [tri_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // status
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    // predictor state
    logic [63:0]           window_lo [TABLE_DEPTH];
    logic [63:0]           window_hi [TABLE_DEPTH];
    logic [31:0]           blk_offset [TABLE_DEPTH];
    logic [31:0]           blk_bytes [TABLE_DEPTH];
    int                    entries_used = 0;
    tri_pkg::t_vtype       cur_vtype = tri_pkg::VT_OTHER;

    t_result               pending_results [$];
    int                    mismatch_count = 0;
    int                    idle_cycles = 0;
    bit                    tx_gaps = 1'b0;
    bit                    rx_stalls = 1'b0;
    int                    rx_hold = 0;

    time_range_index_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // random helpers
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 64'd1000 + $urandom_range(0, 2000);
        if (r < 75) return rand64();
        if (r < 85) return 64'd0;
        if (r < 95) return '1;
        return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(1, 8);
    endfunction

    function automatic logic [31:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 4096);
        if (r < 70) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 64);
    endfunction

    function automatic t_index_cmd random_fill(tri_pkg::t_kind k);
        t_index_cmd c;
        c.kind         = k;
        c.start_time   = rand64();
        c.end_time     = rand64();
        c.entry_bytes  = $urandom;
        c.entry_offset = $urandom;
        c.position     = 6'($urandom_range(0, 63));
        c.query_time   = rand64();
        return c;
    endfunction

    function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // add one expected word at the back of the queue
    task automatic queue_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // expected words for one accepted command
    task automatic predict_command(t_index_cmd c);
        t_result     r;
        t_result     held;
        bit          have_hit;
        logic [31:0] sz;
        int          p;
        r = '0;
        r.last = 1'b1;
        held = '0;
        have_hit = 1'b0;
        p = int'(c.position);
        case (c.kind)
            tri_pkg::KIND_APPEND: begin
                if (entries_used >= TABLE_DEPTH) begin
                    r.status = tri_pkg::STAT_FULL;
                end else begin
                    case (cur_vtype)
                        tri_pkg::VT_BOOL:   sz = tri_pkg::APP_BOOL_BYTES;
                        tri_pkg::VT_INT:    sz = tri_pkg::APP_INT_BYTES;
                        tri_pkg::VT_DOUBLE: sz = tri_pkg::APP_DOUBLE_BYTES;
                        default:            sz = c.entry_bytes;
                    endcase
                    window_lo[entries_used]  = c.start_time;
                    window_hi[entries_used]  = c.end_time;
                    blk_offset[entries_used] = c.entry_offset;
                    blk_bytes[entries_used]  = sz;
                    r.status = tri_pkg::STAT_OK;
                    r.offset = c.entry_offset;
                    r.bytes  = sz;
                    r.index  = entries_used[5:0];
                    entries_used++;
                end
                queue_result(r);
            end
            tri_pkg::KIND_UPDATE: begin
                if (p >= entries_used) begin
                    r.status = tri_pkg::STAT_BAD_POS;
                end else begin
                    window_lo[p] = c.start_time;
                    window_hi[p] = c.end_time;
                    case (cur_vtype)
                        tri_pkg::VT_BOOL:
                            sz = add_clamped(blk_bytes[p], tri_pkg::UPD_BOOL_ADD);
                        tri_pkg::VT_INT:    sz = tri_pkg::UPD_INT_BYTES;
                        tri_pkg::VT_DOUBLE: sz = tri_pkg::UPD_DOUBLE_BYTES;
                        default:            sz = add_clamped(blk_bytes[p], c.entry_bytes);
                    endcase
                    blk_bytes[p] = sz;
                    r.status = tri_pkg::STAT_OK;
                    r.offset = blk_offset[p];
                    r.bytes  = sz;
                    r.index  = c.position;
                end
                queue_result(r);
            end
            default: begin
                // search or list walks the table in index order; a hit is
                // queued once a later hit shows it is not the final word
                for (int i = 0; i < entries_used; i++) begin
                    if (c.kind == tri_pkg::KIND_LIST ||
                        (c.query_time >= window_lo[i] && c.query_time <= window_hi[i])) begin
                        if (have_hit)
                            queue_result(held);
                        held        = '0;
                        held.status = tri_pkg::STAT_OK;
                        held.offset = blk_offset[i];
                        held.bytes  = blk_bytes[i];
                        held.index  = i[5:0];
                        held.last   = 1'b0;
                        have_hit    = 1'b1;
                    end
                end
                if (have_hit) begin
                    held.last = 1'b1;
                    queue_result(held);
                end else begin
                    r.status = tri_pkg::STAT_NO_MATCH;
                    queue_result(r);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // send one command word, predict once it is taken
    task automatic send_command(t_index_cmd c);
        int gap;
        gap = pick_gap(tx_gaps);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.kind;
        s_axis_tdata  <= {2'b00, c.query_time, c.position, c.entry_offset,
                          c.entry_bytes, c.end_time, c.start_time};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_command(c);
    endtask

    // stop sending and wait for every expected word
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_value_type(tri_pkg::t_vtype vt);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= vt;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_vtype = vt;
    endtask

    // short directed builders
    task automatic send_append(logic [63:0] t0, logic [63:0] t1, logic [31:0] off,
                               logic [31:0] nbytes);
        t_index_cmd c;
        c = random_fill(tri_pkg::KIND_APPEND);
        c.start_time   = t0;
        c.end_time     = t1;
        c.entry_offset = off;
        c.entry_bytes  = nbytes;
        send_command(c);
    endtask

    task automatic send_update(logic [5:0] pos, logic [63:0] t0, logic [63:0] t1,
                               logic [31:0] delta);
        t_index_cmd c;
        c = random_fill(tri_pkg::KIND_UPDATE);
        c.position    = pos;
        c.start_time  = t0;
        c.end_time    = t1;
        c.entry_bytes = delta;
        send_command(c);
    endtask

    task automatic send_search(logic [63:0] q);
        t_index_cmd c;
        c = random_fill(tri_pkg::KIND_SEARCH);
        c.query_time = q;
        send_command(c);
    endtask

    // empty table: list, search, updates at both ends of the position range
    task automatic test_empty_table();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_command(random_fill(tri_pkg::KIND_LIST));
        send_search(64'd0);
        send_update(6'd0, 64'd1, 64'd2, 32'd5);
        send_update(6'd63, 64'd1, 64'd2, 32'd5);
    endtask

    // append sizes for each value type, starting from the reset type
    task automatic test_append_sizes();
        send_append(64'd0, '1, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_append(64'd100, 64'd200, 32'd0, 32'd0);
        write_value_type(tri_pkg::VT_BOOL);
        send_append(64'd5, 64'd6, $urandom, $urandom);
        write_value_type(tri_pkg::VT_INT);
        send_append(64'd7, 64'd8, $urandom, $urandom);
        write_value_type(tri_pkg::VT_DOUBLE);
        send_append(64'd9, 64'd10, $urandom, $urandom);
    endtask

    // update sizes, clamping at the top, and positions past the end
    task automatic test_update_sizes();
        rx_stalls = 1'b1;
        write_value_type(tri_pkg::VT_OTHER);
        send_update(6'd0, 64'd0, '1, 32'h20);
        send_update(6'd1, 64'd100, 64'd200, 32'hFFFF_FFFF);
        write_value_type(tri_pkg::VT_BOOL);
        send_update(6'd0, 64'd0, '1, $urandom);
        send_update(6'd2, 64'd200, 64'd300, $urandom);
        write_value_type(tri_pkg::VT_INT);
        send_update(6'd3, 64'd300, 64'd100, $urandom);
        write_value_type(tri_pkg::VT_DOUBLE);
        send_update(6'd4, '1, '1, $urandom);
        send_update(6'd5, 64'd1, 64'd2, $urandom);
        send_update(6'd63, 64'd1, 64'd2, $urandom);
    endtask

    // inclusive bounds, inverted window, top of the time range
    task automatic test_search_bounds();
        tx_gaps = 1'b1;
        send_search(64'd100);
        send_search(64'd200);
        send_search(64'd300);
        send_search('1);
        send_search(64'd0);
        send_search(64'd150);
        send_command(random_fill(tri_pkg::KIND_LIST));
    endtask

    function automatic t_index_cmd random_command();
        t_index_cmd c;
        int         r;
        int         k;
        r = $urandom_range(0, 99);
        if (r < 16) begin
            c = random_fill(tri_pkg::KIND_APPEND);
            c.entry_bytes = pick_bytes();
            c.start_time  = pick_time();
            if ($urandom_range(0, 9) < 7)
                c.end_time = c.start_time + $urandom_range(0, 500);
            else
                c.end_time = pick_time();
        end else if (r < 46) begin
            c = random_fill(tri_pkg::KIND_UPDATE);
            c.entry_bytes = pick_bytes();
            if (entries_used > 0 && $urandom_range(0, 9) < 8)
                c.position = 6'($urandom_range(0, entries_used - 1));
            c.start_time = pick_time();
            if ($urandom_range(0, 9) < 7)
                c.end_time = c.start_time + $urandom_range(0, 500);
            else
                c.end_time = pick_time();
        end else if (r < 80) begin
            c = random_fill(tri_pkg::KIND_SEARCH);
            if (entries_used > 0 && $urandom_range(0, 9) < 7) begin
                // aim at the edges of a stored window
                k = $urandom_range(0, entries_used - 1);
                case ($urandom_range(0, 4))
                    0: c.query_time = window_lo[k];
                    1: c.query_time = window_hi[k];
                    2: c.query_time = window_lo[k] - 64'd1;
                    3: c.query_time = window_hi[k] + 64'd1;
                    default: c.query_time = pick_time();
                endcase
            end
        end else begin
            c = random_fill(tri_pkg::KIND_LIST);
        end
        return c;
    endfunction

    task automatic test_random_traffic(int count, tri_pkg::t_vtype vt, bit gaps, bit stalls);
        write_value_type(vt);
        tx_gaps   = gaps;
        rx_stalls = stalls;
        repeat (count) send_command(random_command());
    endtask

    // fill the table to the top, then appends that find it full
    task automatic test_full_table();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        while (entries_used < TABLE_DEPTH)
            send_append(pick_time(), pick_time(), $urandom, pick_bytes());
        send_append(64'd1, 64'd2, 32'd3, 32'd4);
        send_append(64'd5, 64'd6, 32'd7, 32'd8);
        send_command(random_fill(tri_pkg::KIND_LIST));
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing pending", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[31:0] !== want.offset)
                    report_mismatch("match_offset", 64'(m_axis_tdata[31:0]),
                                    64'(want.offset));
                if (m_axis_tdata[63:32] !== want.bytes)
                    report_mismatch("match_bytes", 64'(m_axis_tdata[63:32]),
                                    64'(want.bytes));
                if (m_axis_tdata[69:64] !== want.index)
                    report_mismatch("entry_index", 64'(m_axis_tdata[69:64]),
                                    64'(want.index));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin : drive_ready
        int g;
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            g = pick_gap(rx_stalls);
            m_axis_tready <= (g == 0);
            rx_hold <= (g > 0) ? g - 1 : 0;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_append_sizes();
        test_update_sizes();
        test_search_bounds();
        test_random_traffic(80, tri_pkg::VT_OTHER, 1'b0, 1'b0);
        test_random_traffic(70, tri_pkg::VT_BOOL, 1'b1, 1'b1);
        test_random_traffic(70, tri_pkg::VT_INT, 1'b1, 1'b0);
        test_random_traffic(70, tri_pkg::VT_DOUBLE, 1'b0, 1'b1);
        test_random_traffic(60, tri_pkg::VT_OTHER, 1'b1, 1'b1);
        test_full_table();
        drain_results();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
